FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of the radix converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked every clock outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication, checked every clock outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: rtl/radc_pkg.sv
// ----------------------------------------------------------------------------
// radc_pkg
// Types, constants and digit/character helpers for the radix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package radc_pkg;

   localparam int VALUE_BITS = 31;
   localparam int MAX_DIGITS = 31;
   localparam int BASE_W     = 6;
   localparam int CHAR_W     = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = BASE_W;

   localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
   localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_BASE      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION = CSR_IDX_W'(1);

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;  // '0'
   localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;  // '9'
   localparam logic [CHAR_W-1:0] CHAR_A      = 8'h41;  // 'A'
   localparam logic [CHAR_W-1:0] CHAR_Z      = 8'h5A;  // 'Z'
   localparam logic [CHAR_W-1:0] ALPHA_OFS   = CHAR_W'(55);  // 'A' - 10
   localparam logic [CHAR_W-1:0] DIGIT_TEN   = CHAR_W'(10);
   localparam logic [CHAR_W-1:0] NOT_A_DIGIT = 8'hFF;

   localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

   typedef struct packed {
      logic [VALUE_BITS-1:0] number_in;
      logic [CHAR_W-1:0]     char_code;
      logic                  end_of_text;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]     digit_char;
      logic                  last_digit;
      logic [VALUE_BITS-1:0] value_out;
      logic                  overflowed;
      logic                  bad_digit;
   } rsp_type;

   // ASCII character to digit value; NOT_A_DIGIT for anything else
   function automatic logic [CHAR_W-1:0] char_to_digit(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] d;
      d = NOT_A_DIGIT;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = c - CHAR_ZERO;
      end else if (c >= CHAR_A && c <= CHAR_Z) begin
         d = c - ALPHA_OFS;
      end
      return d;
   endfunction

   // digit value (below 36) to ASCII character
   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [BASE_W-1:0] d);
      logic [CHAR_W-1:0] dw;
      dw = CHAR_W'(d);
      return (dw < DIGIT_TEN) ? (dw + CHAR_ZERO) : (dw + ALPHA_OFS);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/radix_converter.sv
// ----------------------------------------------------------------------------
// radix_converter
// Binary to base-N digit text and back, N from 2 to 36.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : write base (index 0, clamped to 2..36) or direction (index 1,
//            0 encode, 1 decode) while the block is idle.
//   req_*  : one beat per number (encode) or per character (decode).
//   rsp_*  : encode gives one beat per digit, most significant first, the
//            last one flagged; decode gives one beat on the end character.
// Timing:
//   Encode runs a bit-serial restoring divider by the base, one quotient
//   bit per cycle, for each digit in turn; the digits then leave as result
//   beats at one per cycle while the receiver is ready.
//   Decode folds one character per cycle while req_ready is high (one
//   multiply-add); the end character's result is registered and shows
//   in the cycle after its beat. req_ready is low while dividing or emitting,
//   and while a result is held that the receiver is not taking.
// Reset: base 2, encode, decode run state cleared, no result pending.
// A stalled receiver holds the result register; emission resumes on ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module radix_converter (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  radc_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output radc_pkg::rsp_type                  rsp_data,
   input  wire                                csr_write_en,
   input  wire  [radc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [radc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int VB      = radc_pkg::VALUE_BITS;
   localparam int BW      = radc_pkg::BASE_W;
   localparam int IDX_W   = $clog2(radc_pkg::MAX_DIGITS);
   localparam int CNT_W   = $clog2(radc_pkg::MAX_DIGITS + 1);
   localparam int BIT_W   = $clog2(radc_pkg::VALUE_BITS);
   localparam int PROD_W  = VB + BW;

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_type;

   state_type              state_ff;
   logic [BW-1:0]          base_ff;
   logic                   dir_ff;
   logic [VB-1:0]          acc_ff;
   logic                   ovf_ff;
   logic                   bad_ff;
   logic [VB-1:0]          quo_ff;
   logic [BW-1:0]          rem_ff;
   logic [BIT_W-1:0]       bit_cnt_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic                   rsp_valid_ff;
   radc_pkg::rsp_type      rsp_data_ff;

   logic [BW-1:0]          digit_store [radc_pkg::MAX_DIGITS];

   // divider step
   logic [BW:0]            trial;
   logic                   trial_ge;
   logic [BW-1:0]          rem_in;
   logic [VB-1:0]          quo_in;
   logic                   last_bit;
   logic                   div_done;

   // decode step
   logic [radc_pkg::CHAR_W-1:0] dec_digit;
   logic                   dec_bad;
   logic [PROD_W-1:0]      dec_sum;
   logic [VB-1:0]          acc_in;
   logic                   ovf_in;
   logic                   bad_in;

   logic                   req_fire;
   logic                   slot_free;
   logic                   rsp_load;
   logic [BW-1:0]          base_wr;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a new result beat enters the output register
   assign rsp_load  = (req_fire && dir_ff == radc_pkg::DIR_DECODE && req_data.end_of_text)
                    || (state_ff == ST_EMIT && slot_free);

   always_comb begin
      trial    = {rem_ff, quo_ff[VB-1]};
      trial_ge = trial >= {1'b0, base_ff};
      rem_in   = trial_ge ? BW'(trial - {1'b0, base_ff}) : trial[BW-1:0];
      quo_in   = {quo_ff[VB-2:0], trial_ge};
      last_bit = bit_cnt_ff == BIT_W'(VB - 1);
      div_done = (quo_in == '0) || (cnt_ff == CNT_W'(radc_pkg::MAX_DIGITS - 1));
   end

   always_comb begin
      dec_digit = radc_pkg::char_to_digit(req_data.char_code);
      dec_bad   = dec_digit >= radc_pkg::CHAR_W'(base_ff);
      dec_sum   = PROD_W'({{BW{1'b0}}, acc_ff} * {{VB{1'b0}}, base_ff})
                + PROD_W'(dec_digit);
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      bad_in    = bad_ff;
      if (dec_bad) begin
         bad_in = 1'b1;
      end else if (ovf_ff || dec_sum > PROD_W'(radc_pkg::VALUE_MAX)) begin
         acc_in = radc_pkg::VALUE_MAX;
         ovf_in = 1'b1;
      end else begin
         acc_in = dec_sum[VB-1:0];
      end
   end

   always_comb begin
      if (csr_wdata < radc_pkg::BASE_MIN) begin
         base_wr = radc_pkg::BASE_MIN;
      end else if (csr_wdata > radc_pkg::BASE_MAX) begin
         base_wr = radc_pkg::BASE_MAX;
      end else begin
         base_wr = csr_wdata;
      end
   end

   // digit store: one write per finished digit
   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV && last_bit) begin
         digit_store[cnt_ff[IDX_W-1:0]] <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= radc_pkg::BASE_MIN;
         dir_ff       <= radc_pkg::DIR_ENCODE;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         bad_ff       <= 1'b0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               radc_pkg::CSR_BASE:      base_ff <= base_wr;
               radc_pkg::CSR_DIRECTION: dir_ff  <= csr_wdata[0];
               default: ;
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (dir_ff == radc_pkg::DIR_DECODE) begin
                     if (req_data.end_of_text) begin
                        rsp_data_ff.digit_char  <= '0;
                        rsp_data_ff.last_digit  <= 1'b1;
                        rsp_data_ff.value_out   <= acc_in;
                        rsp_data_ff.overflowed  <= ovf_in;
                        rsp_data_ff.bad_digit   <= bad_in;
                        acc_ff <= '0;
                        ovf_ff <= 1'b0;
                        bad_ff <= 1'b0;
                     end else begin
                        acc_ff <= acc_in;
                        ovf_ff <= ovf_in;
                        bad_ff <= bad_in;
                     end
                  end else begin
                     quo_ff     <= req_data.number_in;
                     rem_ff     <= '0;
                     bit_cnt_ff <= '0;
                     cnt_ff     <= '0;
                     state_ff   <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               quo_ff <= quo_in;
               if (last_bit) begin
                  // digit done: restart the divider on the quotient
                  rem_ff     <= '0;
                  bit_cnt_ff <= '0;
                  cnt_ff     <= cnt_ff + 1'b1;
                  if (div_done) begin
                     idx_ff   <= cnt_ff[IDX_W-1:0];
                     state_ff <= ST_EMIT;
                  end
               end else begin
                  rem_ff     <= rem_in;
                  bit_cnt_ff <= bit_cnt_ff + 1'b1;
               end
            end
            ST_EMIT: begin
               if (slot_free) begin
                  rsp_data_ff.digit_char <= radc_pkg::digit_to_char(digit_store[idx_ff]);
                  rsp_data_ff.last_digit <= idx_ff == '0;
                  rsp_data_ff.value_out  <= '0;
                  rsp_data_ff.overflowed <= 1'b0;
                  rsp_data_ff.bad_digit  <= 1'b0;
                  if (idx_ff == '0) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff <= idx_ff - 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `ASSERT_IMPLY(a_rem_lt_base, clock, reset, state_ff == ST_DIV, rem_ff < base_ff, "bad rem")
   `ASSERT_IMPLY(a_emit_idx, clock, reset, state_ff == ST_EMIT, CNT_W'(idx_ff) < cnt_ff, "bad idx")
   `ASSERT_IMPLY(a_ovf_sat, clock, reset, ovf_ff, acc_ff == radc_pkg::VALUE_MAX, "ovf w/o sat")
   `ASSERT_ALWAYS(a_base_lo, clock, reset, base_ff >= radc_pkg::BASE_MIN, "base below min")
   `ASSERT_ALWAYS(a_base_hi, clock, reset, base_ff <= radc_pkg::BASE_MAX, "base above max")

endmodule

`default_nettype wire
